// ===== hdl/bmt_pkg.sv =====
// ----------------------------------------------------------------------------
// bmt_pkg
// Shared types, codes and arithmetic helpers of the box mesh tessellator.
// ----------------------------------------------------------------------------
package bmt_pkg;

    localparam int COORD_W = 24;
    localparam int TESS_W  = 8;
    localparam int IDX_W   = 19;
    localparam int PROD_W  = COORD_W + TESS_W + 1;

    localparam logic [COORD_W-1:0] SIZE_RESET = 24'd25600;
    localparam logic [TESS_W-1:0]  TESS_RESET = 8'd10;

    localparam logic [2:0] REG_SIZE_X = 3'd0;
    localparam logic [2:0] REG_SIZE_Y = 3'd1;
    localparam logic [2:0] REG_SIZE_Z = 3'd2;
    localparam logic [2:0] REG_TESS_X = 3'd3;
    localparam logic [2:0] REG_TESS_Y = 3'd4;
    localparam logic [2:0] REG_TESS_Z = 3'd5;

    localparam logic [2:0] FACE_TOP    = 3'd0;
    localparam logic [2:0] FACE_BOTTOM = 3'd1;
    localparam logic [2:0] FACE_RIGHT  = 3'd2;
    localparam logic [2:0] FACE_LEFT   = 3'd3;
    localparam logic [2:0] FACE_FRONT  = 3'd4;
    localparam logic [2:0] FACE_BACK   = 3'd5;
    localparam logic [2:0] FACE_DONE   = 3'd6;

    localparam logic [2:0] EDGE_AB_BC = 3'd5;
    localparam logic [2:0] EDGE_BC_CA = 3'd6;
    localparam logic [2:0] EDGE_AB_CA = 3'd3;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_DIVGO,
        ENG_DIVWAIT,
        ENG_CALC,
        ENG_EMIT
    } eng_state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] size_x;
        logic signed [COORD_W-1:0] size_y;
        logic signed [COORD_W-1:0] size_z;
        logic [TESS_W-1:0]         tess_x;
        logic [TESS_W-1:0]         tess_y;
        logic [TESS_W-1:0]         tess_z;
    } cfg_t;

    typedef struct packed {
        logic                      is_triangle;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [IDX_W-1:0]          index_a;
        logic [IDX_W-1:0]          index_b;
        logic [IDX_W-1:0]          index_c;
        logic [2:0]                edge_flags;
        logic [2:0]                face_number;
        logic                      last;
    } out_item_t;

    function automatic logic signed [COORD_W-1:0] half_of(input logic signed [COORD_W-1:0] s);
        logic signed [COORD_W:0] t;
        t = {s[COORD_W-1], s} + {{COORD_W{1'b0}}, s[COORD_W-1]};
        return t[COORD_W:1];
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PROD_W:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > $signed({{(PROD_W-COORD_W+2){1'b0}}, {(COORD_W-1){1'b1}}}))
            r = {1'b0, {(COORD_W-1){1'b1}}};
        else if (v < $signed({{(PROD_W-COORD_W+2){1'b1}}, {(COORD_W-1){1'b0}}}))
            r = {1'b1, {(COORD_W-1){1'b0}}};
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

endpackage

// ===== hdl/bmt_fifo.sv =====
// ----------------------------------------------------------------------------
// bmt_fifo
// Two-entry queue used between front, back and result ports.
// ----------------------------------------------------------------------------
module bmt_fifo #(
    parameter int WIDTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end
endmodule

// ===== hdl/bmt_divider.sv =====
// ----------------------------------------------------------------------------
// bmt_divider
// Iterative signed by unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bmt_divider
    import bmt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [COORD_W-1:0] dividend,
    input  logic [TESS_W-1:0]         divisor,
    output logic                      done,
    output logic [COORD_W-1:0]        quotient
);
    logic [COORD_W-1:0] quo_reg;
    logic [TESS_W-1:0]  rem_reg;
    logic [TESS_W-1:0]  div_reg;
    logic               neg_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [4:0]         cnt_reg;
    logic [TESS_W:0]    trial;
    logic               qbit;
    logic [TESS_W:0]    diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[COORD_W-1]};
        diff  = trial - {1'b0, div_reg};
        qbit  = (trial >= {1'b0, div_reg});
    end

    assign done     = done_reg;
    assign quotient = (div_reg == '0) ? '0 : (neg_reg ? (~quo_reg + 1'b1) : quo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(COORD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend[COORD_W-1] ? (~dividend + 1'b1) : dividend;
            rem_reg <= '0;
            div_reg <= divisor;
            neg_reg <= dividend[COORD_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? diff[TESS_W-1:0] : trial[TESS_W-1:0];
            quo_reg <= {quo_reg[COORD_W-2:0], qbit};
        end
    end
endmodule

// ===== hdl/bmt_engine.sv =====
// ----------------------------------------------------------------------------
// bmt_engine
// Back end: latches steps at restart, walks faces and builds result items.
// ----------------------------------------------------------------------------
module bmt_engine
    import bmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      req_empty,
    input  logic      req_restart,
    output logic      req_pop,
    input  logic      out_full,
    output logic      out_push,
    output out_item_t out_item
);
    eng_state_t state_reg, state_next;

    logic [2:0]               face_reg;
    logic                     tri_reg;
    logic [TESS_W-1:0]        row_reg;
    logic [TESS_W-1:0]        col_reg;
    logic                     second_reg;
    logic [IDX_W-1:0]         base_reg;
    logic signed [COORD_W-1:0] step_reg [3];
    logic                     vol_reg;
    logic [1:0]               axis_reg;

    logic signed [PROD_W-1:0] prod_col_reg;
    logic signed [PROD_W-1:0] prod_row_reg;
    logic [16:0]              rw_reg;
    logic [16:0]              area_reg;

    logic                     div_start;
    logic                     div_done;
    logic [COORD_W-1:0]       div_quot;
    logic signed [COORD_W-1:0] div_size;
    logic [TESS_W-1:0]        div_tess;

    logic [TESS_W-1:0]        rows;
    logic [TESS_W-1:0]        cols;
    logic [TESS_W:0]          c1;
    logic [TESS_W:0]          r1;
    logic                     emit;
    logic                     vol_neg_calc;
    logic [1:0]               neg_count;

    logic signed [COORD_W-1:0] gcol, grow, fixed, hcol, hrow, hfix;
    logic [IDX_W-1:0]          ia, ib, ic, id;
    logic                      topstyle;
    logic                      vert_col_end, vert_row_end;
    logic                      tri_col_end, tri_row_end;

    bmt_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_size),
        .divisor  (div_tess),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        unique case (axis_reg)
            2'd0:    begin div_size = cfg.size_x; div_tess = cfg.tess_x; end
            2'd1:    begin div_size = cfg.size_y; div_tess = cfg.tess_y; end
            default: begin div_size = cfg.size_z; div_tess = cfg.tess_z; end
        endcase
    end

    always_comb
    begin
        neg_count = 2'(cfg.size_x[COORD_W-1]) + 2'(cfg.size_y[COORD_W-1])
                  + 2'(cfg.size_z[COORD_W-1]);
        vol_neg_calc = neg_count[0] && (cfg.size_x != '0) && (cfg.size_y != '0)
                     && (cfg.size_z != '0);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ENG_IDLE:
            begin
                if (!req_empty)
                begin
                    if (req_restart)
                        state_next = ENG_DIVGO;
                    else if (face_reg < FACE_DONE)
                        state_next = ENG_CALC;
                end
            end
            ENG_DIVGO:   state_next = ENG_DIVWAIT;
            ENG_DIVWAIT:
            begin
                if (div_done)
                    state_next = (axis_reg == 2'd2) ? ENG_CALC : ENG_DIVGO;
            end
            ENG_CALC:    state_next = ENG_EMIT;
            ENG_EMIT:
            begin
                if (!out_full)
                    state_next = ENG_IDLE;
            end
            default:     state_next = ENG_IDLE;
        endcase
    end

    always_comb
    begin
        req_pop   = (state_reg == ENG_IDLE) && !req_empty;
        div_start = (state_reg == ENG_DIVGO);
        out_push  = (state_reg == ENG_EMIT) && !out_full;
    end

    assign emit = out_push;

    always_comb
    begin
        rows = (face_reg >= FACE_FRONT) ? cfg.tess_x : cfg.tess_z;
        cols = (face_reg <= FACE_BOTTOM) ? cfg.tess_x : cfg.tess_y;
        c1   = {1'b0, cols} + 1'b1;
        r1   = {1'b0, rows} + 1'b1;

        hcol = half_of((face_reg <= FACE_BOTTOM) ? cfg.size_x : cfg.size_y);
        hrow = half_of((face_reg >= FACE_FRONT) ? cfg.size_x : cfg.size_z);
        unique case (face_reg)
            FACE_TOP, FACE_BOTTOM:  hfix = half_of(cfg.size_y);
            FACE_RIGHT, FACE_LEFT:  hfix = half_of(cfg.size_x);
            default:                hfix = half_of(cfg.size_z);
        endcase
        gcol  = sat_coord((PROD_W+1)'(prod_col_reg) - (PROD_W+1)'(hcol));
        grow  = sat_coord((PROD_W+1)'(prod_row_reg) - (PROD_W+1)'(hrow));
        fixed = face_reg[0] ? -hfix : hfix;

        ia = base_reg + IDX_W'(col_reg) + IDX_W'(rw_reg);
        ib = ia + IDX_W'(c1);
        ic = ia + 1'b1;
        id = ib + 1'b1;
        topstyle = (face_reg == FACE_TOP) || (face_reg == FACE_LEFT)
                || (face_reg == FACE_FRONT);

        vert_col_end = ({1'b0, col_reg} + 1'b1) > {1'b0, cols};
        vert_row_end = ({1'b0, row_reg} + 1'b1) > {1'b0, rows};
        tri_col_end  = ({1'b0, col_reg} + 1'b1) >= {1'b0, cols};
        tri_row_end  = ({1'b0, row_reg} + 1'b1) >= {1'b0, rows};
    end

    always_comb
    begin
        out_item             = '0;
        out_item.face_number = face_reg;
        if (!tri_reg)
        begin
            unique case (face_reg)
                FACE_TOP, FACE_BOTTOM:
                begin
                    out_item.coord_x = gcol;
                    out_item.coord_y = fixed;
                    out_item.coord_z = grow;
                end
                FACE_RIGHT, FACE_LEFT:
                begin
                    out_item.coord_x = fixed;
                    out_item.coord_y = gcol;
                    out_item.coord_z = grow;
                end
                default:
                begin
                    out_item.coord_x = grow;
                    out_item.coord_y = gcol;
                    out_item.coord_z = fixed;
                end
            endcase
        end
        else
        begin
            out_item.is_triangle = 1'b1;
            if (topstyle)
            begin
                if (!second_reg)
                begin
                    out_item.index_a    = ia;
                    out_item.index_b    = vol_reg ? ic : ib;
                    out_item.index_c    = vol_reg ? ib : ic;
                    out_item.edge_flags = EDGE_AB_BC;
                end
                else
                begin
                    out_item.index_a    = ic;
                    out_item.index_b    = vol_reg ? id : ib;
                    out_item.index_c    = vol_reg ? ib : id;
                    out_item.edge_flags = vol_reg ? EDGE_AB_CA : EDGE_BC_CA;
                end
            end
            else
            begin
                if (!second_reg)
                begin
                    out_item.index_a    = vol_reg ? ib : ic;
                    out_item.index_b    = vol_reg ? ic : ib;
                    out_item.index_c    = ia;
                    out_item.edge_flags = EDGE_BC_CA;
                end
                else
                begin
                    out_item.index_a    = vol_reg ? ib : id;
                    out_item.index_b    = vol_reg ? id : ib;
                    out_item.index_c    = ic;
                    out_item.edge_flags = vol_reg ? EDGE_AB_CA : EDGE_AB_BC;
                end
            end
            out_item.last = second_reg && tri_col_end && tri_row_end
                         && (face_reg == FACE_BACK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ENG_IDLE;
            face_reg   <= FACE_TOP;
            tri_reg    <= 1'b0;
            row_reg    <= '0;
            col_reg    <= '0;
            second_reg <= 1'b0;
            base_reg   <= '0;
            step_reg   <= '{default: '0};
            vol_reg    <= 1'b0;
            axis_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (req_pop && req_restart)
            begin
                face_reg   <= FACE_TOP;
                tri_reg    <= 1'b0;
                row_reg    <= '0;
                col_reg    <= '0;
                second_reg <= 1'b0;
                base_reg   <= '0;
                vol_reg    <= vol_neg_calc;
                axis_reg   <= '0;
            end
            if ((state_reg == ENG_DIVWAIT) && div_done)
            begin
                step_reg[axis_reg] <= div_quot;
                axis_reg           <= axis_reg + 2'd1;
            end
            if (emit)
            begin
                if (!tri_reg)
                begin
                    if (vert_col_end)
                    begin
                        col_reg <= '0;
                        if (vert_row_end)
                        begin
                            if ((rows == '0) || (cols == '0))
                            begin
                                base_reg <= base_reg + IDX_W'(area_reg);
                                face_reg <= face_reg + 3'd1;
                                row_reg  <= '0;
                            end
                            else
                            begin
                                row_reg <= '0;
                                tri_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            row_reg <= row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                else if (!second_reg)
                begin
                    second_reg <= 1'b1;
                end
                else
                begin
                    second_reg <= 1'b0;
                    if (tri_col_end)
                    begin
                        col_reg <= '0;
                        if (tri_row_end)
                        begin
                            base_reg <= base_reg + IDX_W'(area_reg);
                            face_reg <= face_reg + 3'd1;
                            tri_reg  <= 1'b0;
                            row_reg  <= '0;
                        end
                        else
                        begin
                            row_reg <= row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ENG_CALC)
        begin
            prod_col_reg <= ((face_reg <= FACE_BOTTOM) ? step_reg[0] : step_reg[1])
                          * $signed({1'b0, col_reg});
            prod_row_reg <= ((face_reg >= FACE_FRONT) ? step_reg[0] : step_reg[2])
                          * $signed({1'b0, row_reg});
            rw_reg       <= 17'(row_reg * c1);
            area_reg     <= 17'(r1 * c1);
        end
    end
endmodule

// ===== hdl/box_mesh_tessellator.sv =====
// ----------------------------------------------------------------------------
// box_mesh_tessellator
// Streams box mesh vertices and triangles, one per request until the walk ends.
// Flow: a request passes the request queue, the engine's calc and emit states
//   and the result queue; a restart first runs three serial step divisions.
// One request is served at a time; emit stalls while the result queue is full.
// Reset: asynchronous; registers return to size 100.0 and 10 cells, walk
//   restarts at the top face with zero steps; queues empty.
// ----------------------------------------------------------------------------
module box_mesh_tessellator
    import bmt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [COORD_W-1:0]        cfg_data,
    input  logic                      push,
    output logic                      full,
    input  logic                      restart,
    output logic                      empty,
    input  logic                      pop,
    output logic                      is_triangle,
    output logic signed [COORD_W-1:0] coord_x,
    output logic signed [COORD_W-1:0] coord_y,
    output logic signed [COORD_W-1:0] coord_z,
    output logic [IDX_W-1:0]          index_a,
    output logic [IDX_W-1:0]          index_b,
    output logic [IDX_W-1:0]          index_c,
    output logic [2:0]                edge_flags,
    output logic [2:0]                face_number,
    output logic                      last
);
    cfg_t      cfg_reg;
    logic      req_empty, req_pop, req_restart;
    logic      out_full, out_push;
    out_item_t eng_item, res_item;
    logic [$bits(out_item_t)-1:0] res_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_x <= SIZE_RESET;
            cfg_reg.size_y <= SIZE_RESET;
            cfg_reg.size_z <= SIZE_RESET;
            cfg_reg.tess_x <= TESS_RESET;
            cfg_reg.tess_y <= TESS_RESET;
            cfg_reg.tess_z <= TESS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SIZE_X: cfg_reg.size_x <= cfg_data;
                REG_SIZE_Y: cfg_reg.size_y <= cfg_data;
                REG_SIZE_Z: cfg_reg.size_z <= cfg_data;
                REG_TESS_X: cfg_reg.tess_x <= cfg_data[TESS_W-1:0];
                REG_TESS_Y: cfg_reg.tess_y <= cfg_data[TESS_W-1:0];
                REG_TESS_Z: cfg_reg.tess_z <= cfg_data[TESS_W-1:0];
                default: ;
            endcase
        end
    end

    bmt_fifo #(.WIDTH(1)) u_req_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (restart),
        .full  (full),
        .pop   (req_pop),
        .dout  (req_restart),
        .empty (req_empty)
    );

    bmt_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .req_empty   (req_empty),
        .req_restart (req_restart),
        .req_pop     (req_pop),
        .out_full    (out_full),
        .out_push    (out_push),
        .out_item    (eng_item)
    );

    bmt_fifo #(.WIDTH($bits(out_item_t))) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (eng_item),
        .full  (out_full),
        .pop   (pop),
        .dout  (res_bits),
        .empty (empty)
    );

    assign res_item    = res_bits;
    assign is_triangle = res_item.is_triangle;
    assign coord_x     = res_item.coord_x;
    assign coord_y     = res_item.coord_y;
    assign coord_z     = res_item.coord_z;
    assign index_a     = res_item.index_a;
    assign index_b     = res_item.index_b;
    assign index_c     = res_item.index_c;
    assign edge_flags  = res_item.edge_flags;
    assign face_number = res_item.face_number;
    assign last        = res_item.last;
endmodule
